// ----- design/glmc_pkg.sv -----
// Shared types and constants for the grid local-maxima counter.
// No dependencies; imported by glmc_eval, grid_local_maxima_count and tb.
package glmc_pkg;

    localparam int TEMP_W  = 16;
    localparam int COUNT_W = 12;
    localparam int CFG_W   = 7;

    localparam logic [CFG_W-1:0]   GRID_SIZE_RESET = 7'd2;
    localparam logic [COUNT_W-1:0] COUNT_LIMIT     = 12'd4095;

    typedef logic signed [TEMP_W-1:0] temp_t;
    typedef logic [COUNT_W-1:0]       count_t;

    // Where the word sits in the grid, as seen by the evaluation stage
    typedef struct packed {
        logic col_first;
        logic row_first;
        logic last_row;
        logic last_col;
    } pos_info_t;

    // Evaluation results for one word
    typedef struct packed {
        logic       cell_flag;    // word still beats every neighbor seen so far
        logic       left_beaten;  // left cell is not above this word
        logic [1:0] add;          // cells settled as maxima by this word
    } eval_out_t;

endpackage

// ----- design/grid_local_maxima_count.sv -----
// Top level of the grid local-maxima counter: position tracking, line buffer,
// evaluation stage and result register. Depends on glmc_pkg, glmc_ram, glmc_eval.
//
//  channel | signals                        | direction | payload
//  --------+--------------------------------+-----------+------------------------
//  in      | in_valid / in_ready            | sink      | temperature (s16)
//  out     | out_valid / out_ready          | source    | critical_count (u12)
//  cfg     | cfg_wr_en / cfg_wr_data        | sink      | grid_size (u7), no wait
//
// One word per clock sustained, but for the stall below. A word is held in the
// input register while the line-buffer RAM read for its column completes, then
// is evaluated and retired; the count of a frame is registered in the output
// register when its last word retires. Only the last word of a frame stalls,
// and only while the output register is full and out_ready is low; words behind
// a stalled last word wait with it, other words never wait on out_ready.
// Reset (rst_n, async, active low) clears position, count, flags, left cell
// and grid_size (back to 2); line-buffer values are not cleared and need none.
module grid_local_maxima_count
    import glmc_pkg::*;
#(
    parameter int MAX_SIZE = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  temp_t              temperature,
    output logic               out_valid,
    input  logic               out_ready,
    output count_t             critical_count,
    input  logic               cfg_wr_en,
    input  logic [CFG_W-1:0]   cfg_wr_data
);

    // index width for a column/row; compare width fits both MAX_SIZE and grid_size
    localparam int IDX_W = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;
    localparam int CW    = (IDX_W + 1 > CFG_W) ? IDX_W + 1 : CFG_W;
    localparam logic [CW-1:0] MAX_C = CW'(MAX_SIZE);

    typedef logic [IDX_W-1:0] idx_t;

    // ---------------- configuration ----------------
    logic [CFG_W-1:0] grid_size_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_size_reg <= GRID_SIZE_RESET;
        end
        else if (cfg_wr_en)
        begin
            grid_size_reg <= cfg_wr_data;
        end
    end

    // ---------------- stage 1: position and line read ----------------
    idx_t      row_reg, row_next;
    idx_t      col_reg, col_next;
    logic      in_accept;
    logic [CW-1:0] n_ext, n_eff, n_last;
    logic      drop;
    idx_t      pos_r, pos_c;
    pos_info_t pos_in;

    logic      s1_valid_reg;
    temp_t     s1_temp_reg;
    pos_info_t s1_pos_reg;
    idx_t      s1_col_reg;
    logic      s1_drop_reg;
    logic      s1_byp_reg;
    temp_t     s1_byp_data_reg;
    logic      s1_last;
    logic      s1_fire;
    logic      byp;

    assign in_accept = in_valid && in_ready;

    always_comb
    begin
        n_ext = CW'(grid_size_reg);
        // size 0 acts as 1, anything above the line depth is clamped
        if (n_ext == '0)
        begin
            n_eff = CW'(1);
        end
        else if (n_ext > MAX_C)
        begin
            n_eff = MAX_C;
        end
        else
        begin
            n_eff = n_ext;
        end
        n_last = n_eff - CW'(1);

        // stored position outside a resized grid: drop partial frame
        drop  = (CW'(row_reg) >= n_eff) || (CW'(col_reg) >= n_eff);
        pos_r = drop ? '0 : row_reg;
        pos_c = drop ? '0 : col_reg;

        pos_in.col_first = (pos_c == '0);
        pos_in.row_first = (pos_r == '0);
        pos_in.last_row  = (CW'(pos_r) == n_last);
        pos_in.last_col  = (CW'(pos_c) == n_last);

        row_next = row_reg;
        col_next = col_reg;
        if (in_accept)
        begin
            if (pos_in.last_col)
            begin
                col_next = '0;
                row_next = pos_in.last_row ? '0 : pos_r + IDX_W'(1);
            end
            else
            begin
                col_next = pos_c + IDX_W'(1);
                row_next = pos_r;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg <= '0;
            col_reg <= '0;
        end
        else
        begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

    // same-column read while the previous word is still being written
    assign byp = s1_fire && (pos_c == s1_col_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            s1_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_temp_reg     <= temperature;
            s1_pos_reg      <= pos_in;
            s1_col_reg      <= pos_c;
            s1_drop_reg     <= drop;
            s1_byp_reg      <= byp;
            s1_byp_data_reg <= s1_temp_reg;
        end
    end

    // line buffer of the row above: values only, flags live in flops
    temp_t above_ram;

    glmc_ram #(
        .WIDTH (TEMP_W),
        .DEPTH (MAX_SIZE)
    ) u_line (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (s1_temp_reg),
        .rd_en   (in_accept),
        .rd_addr (pos_c),
        .rd_data (above_ram)
    );

    // ---------------- stage 2: evaluate and retire ----------------
    temp_t               left_value_reg;
    logic                left_flag_reg;
    logic [MAX_SIZE-1:0] flags_reg, flags_next;
    logic                s1_aflag_reg;
    count_t              count_reg, count_next;
    count_t              count_base;
    logic [COUNT_W:0]    count_wide;
    count_t              count_sum;
    temp_t               above_value;
    eval_out_t           ev;
    logic                out_valid_reg;
    count_t              out_count_reg;

    assign above_value = s1_byp_reg ? s1_byp_data_reg : above_ram;

    glmc_eval u_eval (
        .cur_value   (s1_temp_reg),
        .left_value  (left_value_reg),
        .left_flag   (left_flag_reg),
        .above_value (above_value),
        .above_flag  (s1_aflag_reg),
        .pos         (s1_pos_reg),
        .res         (ev)
    );

    assign s1_last  = s1_pos_reg.last_row && s1_pos_reg.last_col;
    assign s1_fire  = s1_valid_reg && (!s1_last || !out_valid_reg || out_ready);
    assign in_ready = !s1_valid_reg || s1_fire;

    always_comb
    begin
        count_base = s1_drop_reg ? '0 : count_reg;
        count_wide = {1'b0, count_base} + (COUNT_W + 1)'(ev.add);
        count_sum  = (count_wide > {1'b0, COUNT_LIMIT}) ? COUNT_LIMIT
                                                          : count_wide[COUNT_W-1:0];

        flags_next = flags_reg;
        count_next = count_reg;
        if (s1_fire)
        begin
            if (ev.left_beaten)
            begin
                flags_next[s1_col_reg - IDX_W'(1)] = 1'b0;
            end
            flags_next[s1_col_reg] = ev.cell_flag;
            count_next = s1_last ? '0 : count_sum;
        end
    end

    // flag of the cell above, read at accept with this edge's updates applied
    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s1_aflag_reg <= flags_next[pos_c];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_value_reg <= '0;
            left_flag_reg  <= 1'b0;
            flags_reg      <= '0;
            count_reg      <= '0;
        end
        else
        begin
            flags_reg <= flags_next;
            count_reg <= count_next;
            if (s1_fire)
            begin
                left_value_reg <= s1_temp_reg;
                left_flag_reg  <= ev.cell_flag;
            end
        end
    end

    // result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s1_fire && s1_last)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s1_last)
        begin
            out_count_reg <= count_sum;
        end
    end

    assign out_valid      = out_valid_reg;
    assign critical_count = out_count_reg;

    // ---------------- assertions ----------------
    a_frame_result: assert property (@(posedge clk) disable iff (!rst_n)
        s1_fire && s1_last |=> out_valid_reg && (out_count_reg == $past(count_sum)))
        else $error("frame count not captured in result register");

    a_stage_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s1_valid_reg && !s1_fire |=> s1_valid_reg && $stable(s1_temp_reg)
                                     && $stable(s1_col_reg))
        else $error("stalled word lost or changed in input register");

    a_frame_wrap: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && pos_in.last_row && pos_in.last_col |=> (row_reg == '0) && (col_reg == '0))
        else $error("position not cleared after last cell of frame");

endmodule

// ----- design/glmc_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
module glmc_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 64
) (
    input  logic                                    clk,
    input  logic                                    wr_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                        wr_data,
    input  logic                                    rd_en,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                        rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ----- design/glmc_eval.sv -----
// Neighbor comparisons for one grid word: own candidate flag, left-cell kill,
// and number of cells settled as maxima. Depends on glmc_pkg.
module glmc_eval
    import glmc_pkg::*;
(
    input  temp_t     cur_value,
    input  temp_t     left_value,
    input  logic      left_flag,
    input  temp_t     above_value,
    input  logic      above_flag,
    input  pos_info_t pos,
    output eval_out_t res
);

    logic left_ok;
    logic above_ok;
    logic left_final;
    logic above_final;
    logic own_final;

    always_comb
    begin
        left_ok  = pos.col_first || (cur_value > left_value);
        above_ok = pos.row_first || (cur_value > above_value);

        res.left_beaten = !pos.col_first && (left_value <= cur_value);
        res.cell_flag   = left_ok && above_ok;

        // last row: left cell has no down neighbor, so it settles now
        left_final  = !pos.col_first && pos.last_row && left_flag && !res.left_beaten;
        // cell above has now seen its down neighbor
        above_final = !pos.row_first && above_flag && (above_value > cur_value);
        // bottom-right corner settles itself
        own_final   = pos.last_row && pos.last_col && res.cell_flag;

        res.add = {1'b0, left_final} + {1'b0, above_final} + {1'b0, own_final};
    end

endmodule

// ----- dv/tb.sv -----
// Self-checking testbench for grid_local_maxima_count: random and directed grids,
// an in-bench count of strict four-neighbor maxima, and checks of every result word.
// Depends on glmc_pkg and the grid_local_maxima_count RTL.
`timescale 1ns / 100ps

module tb;
    import glmc_pkg::*;

    localparam int MAX_GRID        = 64;
    localparam int PEAK_GRID       = 32;    // side of the directed checkerboard grid
    localparam int LONG_HOLD       = 300;   // receiver hold-off, in cycles
    localparam int WATCHDOG_LIMIT  = 3000;  // cycles with no word moving on the in or out channel
    localparam int SETTLE_CYCLES   = 4;     // margin for the pipeline to empty
    localparam int RANDOM_WORDS    = 400;

    // How the values of a grid are drawn
    typedef enum int {
        VAL_RANDOM,   // full 16-bit range
        VAL_TIES,     // tiny range, many equal neighbors
        VAL_EXTREME,  // only the ends of the signed range
        VAL_PEAKS     // checkerboard of strict peaks
    } value_style_t;

    // Receiver back-pressure patterns, picked at random per window of rx_tick
    typedef enum int {
        RX_ALWAYS,
        RX_MOSTLY,
        RX_PERIODIC,
        RX_RARELY
    } rx_style_t;

    logic             clk         = 1'b0;
    logic             rst_n       = 1'b0;
    logic             in_valid    = 1'b0;
    logic             in_ready;
    temp_t            temperature = '0;
    logic             out_valid;
    logic             out_ready   = 1'b0;
    count_t           critical_count;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;

    grid_local_maxima_count #(
        .MAX_SIZE (MAX_GRID)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .temperature    (temperature),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .critical_count (critical_count),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Expected behavior: our own copy of the line buffer, the left cell,
    // the raster position and the running count. Updated once per word
    // taken by the block, in the monitor below.
    // ------------------------------------------------------------------
    temp_t            line_vals    [MAX_GRID];
    bit               line_flags   [MAX_GRID];
    bit               line_written [MAX_GRID];  // column ever stored since reset
    temp_t            left_val     = '0;
    bit               left_flg     = 1'b0;
    int unsigned      row_pos      = 0;
    int unsigned      col_pos      = 0;
    int unsigned      run_count    = 0;
    logic [CFG_W-1:0] size_reg     = GRID_SIZE_RESET;

    count_t           expected_counts [$];
    temp_t            word_queue      [$];
    int               words_pushed  = 0;
    int               words_taken   = 0;
    int               error_count   = 0;
    int               quiet_cycles  = 0;
    int               hold_requests = 0;

    // Size 0 acts as 1, anything past the line length acts as the line length
    function automatic int unsigned eff_size(input logic [CFG_W-1:0] s);
        if (s == 0)
            return 1;
        if (s > MAX_GRID)
            return MAX_GRID;
        return s;
    endfunction

    // Settles the flags touched by one word; returns 1 with the frame count on
    // the last cell of a frame.
    function automatic bit advance_grid(input temp_t t, output count_t cnt);
        int unsigned n;
        int unsigned r;
        int unsigned c;
        int unsigned add;
        bit          flag;
        bit          above_flag;
        bit          done;
        n    = eff_size(size_reg);
        r    = row_pos;
        c    = col_pos;
        add  = 0;
        flag = 1'b1;
        done = 1'b0;
        cnt  = '0;
        // position outside a shrunk grid: partial frame is thrown away
        if (r >= n || c >= n)
        begin
            r         = 0;
            c         = 0;
            run_count = 0;
        end
        if (c > 0)
        begin
            if (t <= left_val)
                flag = 1'b0;
            if (left_val <= t)
            begin
                left_flg         = 1'b0;
                line_flags[c-1]  = 1'b0;
            end
            // last row: left cell has no down neighbor, so it is final now
            if (r == n - 1 && left_flg)
                add++;
        end
        if (r > 0)
        begin
            above_flag = line_flags[c];
            if (t <= line_vals[c])
                flag = 1'b0;
            if (line_vals[c] <= t)
                above_flag = 1'b0;
            // cell above has now seen all of its neighbors
            if (above_flag)
                add++;
        end
        if (r == n - 1 && c == n - 1 && flag)
            add++;
        line_vals[c]    = t;
        line_flags[c]   = flag;
        line_written[c] = 1'b1;
        left_val        = t;
        left_flg        = flag;
        run_count       = run_count + add;
        if (run_count > COUNT_LIMIT)
            run_count = COUNT_LIMIT;
        if (c == n - 1)
        begin
            c = 0;
            if (r == n - 1)
            begin
                cnt       = count_t'(run_count);
                done      = 1'b1;
                r         = 0;
                run_count = 0;
            end
            else
                r++;
        end
        else
            c++;
        row_pos = r;
        col_pos = c;
        return done;
    endfunction

    // A size change that keeps the frame going must not expose a line entry
    // that was never stored; in that case pick a size that drops the frame.
    function automatic logic [CFG_W-1:0] safe_grid_size(input logic [CFG_W-1:0] want);
        int unsigned n;
        n = eff_size(want);
        if (row_pos > 0 && row_pos < n && col_pos < n)
            for (int i = col_pos; i < n; i++)
                if (!line_written[i])
                    return CFG_W'(row_pos);
        return want;
    endfunction

    function automatic temp_t pick_temperature(input value_style_t style, input int r,
                                               input int c);
        case (style)
            VAL_TIES:
                return temp_t'(int'($urandom_range(0, 4)) - 2);
            VAL_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return temp_t'(32767);
                    1:       return temp_t'(-32768);
                    2:       return temp_t'(32766);
                    default: return temp_t'(-32767);
                endcase
            VAL_PEAKS:
                // even cells strictly above every odd cell
                if ((r + c) % 2 == 0)
                    return temp_t'($urandom_range(1000, 32767));
                else
                    return temp_t'(int'($urandom_range(0, 33767)) - 32768);
            default:
                return temp_t'($urandom);
        endcase
    endfunction

    task automatic note_failure(input string what);
        error_count++;
        if (error_count <= 10)
            $display("%0t: %s", $time, what);
    endtask

    // ------------------------------------------------------------------
    // Input driver: bursts of random length, random gaps between them.
    // Valid holds with a steady word until the block takes it.
    // ------------------------------------------------------------------
    int burst_left = 1;
    int gap_left   = 0;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid    <= 1'b0;
            temperature <= '0;
        end
        else if (!in_valid || in_ready)
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (word_queue.size() > 0)
            begin
                in_valid    <= 1'b1;
                temperature <= word_queue.pop_front();
                if (burst_left <= 1)
                begin
                    burst_left = $urandom_range(1, 48);
                    gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                end
                else
                    burst_left--;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Result receiver: its own stall pattern, plus a long hold-off on
    // request so the output register fills and the input stalls.
    // ------------------------------------------------------------------
    int        hold_served = 0;
    int        hold_left   = 0;
    int        rx_tick     = 0;
    rx_style_t rx_style    = RX_ALWAYS;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_ready <= 1'b0;
        else
        begin
            if (hold_served != hold_requests)
            begin
                hold_served = hold_requests;
                hold_left   = LONG_HOLD;
            end
            rx_tick++;
            if (rx_tick % 64 == 0)
                rx_style = rx_style_t'($urandom_range(0, 3));
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
                case (rx_style)
                    RX_MOSTLY:   out_ready <= ($urandom_range(0, 9) < 7);
                    RX_PERIODIC: out_ready <= (rx_tick % 5 >= 2);
                    RX_RARELY:   out_ready <= ($urandom_range(0, 9) < 3);
                    default:     out_ready <= 1'b1;
                endcase
        end
    end

    // ------------------------------------------------------------------
    // Monitor: tracks configuration writes, works out the expected count
    // for each word taken, and checks each count word handed out.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        count_t frame_count;
        count_t want;
        if (rst_n)
        begin
            if (cfg_wr_en)
                size_reg = cfg_wr_data;
            if (in_valid && in_ready)
            begin
                words_taken++;
                if (advance_grid(temperature, frame_count))
                    expected_counts.push_back(frame_count);
            end
            if (out_valid && out_ready)
            begin
                if (expected_counts.size() == 0)
                    note_failure($sformatf("count %0d with none pending", critical_count));
                else
                begin
                    want = expected_counts.pop_front();
                    if (critical_count !== want)
                        note_failure($sformatf("critical_count expected %0d got %0d",
                                               want, critical_count));
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Watchdog: a stuck handshake ends the run
    initial
    begin
        while (quiet_cycles < WATCHDOG_LIMIT)
            @(posedge clk);
        $display("tb failed");
        $finish;
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    task automatic add_word(input temp_t t);
        word_queue.push_back(t);
        words_pushed++;
    endtask

    task automatic push_frame(input int unsigned n, input value_style_t style);
        for (int r = 0; r < n; r++)
            for (int c = 0; c < n; c++)
                add_word(pick_temperature(style, r, c));
    endtask

    // words with no frame alignment, usually leaving a partial frame behind
    task automatic push_words(input int unsigned count, input value_style_t style);
        for (int i = 0; i < count; i++)
            add_word(pick_temperature(style, i / 8, i));
    endtask

    // every word taken, every count returned, pipeline given time to empty
    task automatic wait_idle();
        while (words_taken != words_pushed || expected_counts.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_grid_size(input logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
    endtask

    initial
    begin : stimulus
        int unsigned      n;
        int               base;
        int               frames;
        logic [CFG_W-1:0] want;
        value_style_t     style;
        foreach (line_vals[i])
        begin
            line_vals[i]    = '0;
            line_flags[i]   = 1'b0;
            line_written[i] = 1'b0;
        end
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Directed: reset size 2, diagonal peaks at both ends of the range
        add_word(temp_t'(32767));
        add_word(temp_t'(-32768));
        add_word(temp_t'(-32768));
        add_word(temp_t'(32767));
        wait_idle();
        // 1x1 grid counts its single cell
        write_grid_size(CFG_W'(1));
        add_word(temp_t'(-32768));
        add_word(temp_t'(32767));
        wait_idle();
        // size zero behaves as one
        write_grid_size(CFG_W'(0));
        add_word(temp_t'(0));
        wait_idle();
        // flat 3x3: equal neighbors never count
        write_grid_size(CFG_W'(3));
        repeat (9) add_word(temp_t'(5));
        wait_idle();

        // Large grid, checkerboard: every other cell is a peak
        write_grid_size(CFG_W'(PEAK_GRID));
        push_frame(PEAK_GRID, VAL_PEAKS);
        wait_idle();

        // Receiver holds off while 1x1 frames keep coming: output fills, input stalls
        write_grid_size(CFG_W'(1));
        push_words(60, VAL_RANDOM);
        hold_requests++;
        wait_idle();

        // Random phases: mostly small grids, some mid-sized, rare extremes and
        // oversized settings, partial frames left behind for mid-frame changes
        base = words_pushed;
        while (words_pushed - base < RANDOM_WORDS)
        begin
            case ($urandom_range(0, 19))
                0:       want = CFG_W'(0);
                1:       want = CFG_W'($urandom_range(MAX_GRID + 1, 127));
                2:       want = CFG_W'(MAX_GRID);
                3, 4:    want = CFG_W'($urandom_range(11, 32));
                default: want = CFG_W'($urandom_range(1, 10));
            endcase
            want  = safe_grid_size(want);
            write_grid_size(want);
            n     = eff_size(want);
            style = value_style_t'($urandom_range(0, 3));
            if (n > 32)
                push_words($urandom_range(5, 3 * n), style);
            else
            begin
                frames = (n > 10) ? 1 : $urandom_range(1, 4);
                repeat (frames) push_frame(n, style);
                if (n > 1 && $urandom_range(0, 2) == 0)
                    push_words($urandom_range(1, n * n - 1), style);
            end
            wait_idle();
        end

        repeat (20) @(posedge clk);
        if (error_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule

// ----- files.f -----
design/glmc_pkg.sv
design/glmc_ram.sv
design/glmc_eval.sv
design/grid_local_maxima_count.sv
dv/tb.sv
